FILE: hdl/sawbc_pkg.sv
`timescale 1ns / 1ps

package sawbc_pkg;

   // action codes carried on req_tuser
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 32;

   // response payload: read_data, was_hit, wrote_back, hit_total, miss_total
   localparam int RSP_FIELDS_W = BYTE_W + 2 + 2 * TOTAL_W;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

FILE: hdl/set_associative_write_back_cache_core.sv
`timescale 1ns / 1ps

// byte-wide set-associative write-back, write-allocate cache with true lru
// replacement, sitting in front of its own main memory model
// req channel: one byte read or write per transaction; tuser holds the action
// (read or write), tdata holds the byte address and the write byte
// rsp channel: one transaction per request with the byte, hit and write-back
// flags, and the running hit and miss totals (both wrap at 32 bits)
// sequence: lookup walks the ways one at a time through the single line
// state port, and the lru update walks them again after the access; a miss
// first writes back a dirty victim, then fills the block from main memory,
// each block byte moving through one data store port and one memory port
// throughput: one request at a time; req_tready is high only while idle, so
// the next request is taken only after the response has been loaded
// reset: clears the totals at once, then sweeps main memory to zero one byte
// a cycle, setting up the line state in the first SETS*WAYS steps of the
// sweep, with req_tready held low throughout
// stall: a finished response waits in the output register while rsp_tready
// is low; the next request can be accepted and worked on meanwhile, but its
// response is only loaded once the waiting one has been taken
module set_associative_write_back_cache_core #(
   parameter int WAYS        = 4,
   parameter int SETS        = 64,
   parameter int BLOCK_BYTES = 32,
   parameter int ADDR_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // address [ADDR_BITS-1:0], write_data [ADDR_BITS+7:ADDR_BITS], zero fill
   input  logic [((ADDR_BITS + 8 + 7) / 8) * 8 - 1:0] req_tdata,
   // action
   input  logic [0:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // read_data [7:0], was_hit [8], wrote_back [9], hit_total [41:10],
   // miss_total [73:42], zero fill
   output logic [sawbc_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int OFF_W   = $clog2(BLOCK_BYTES);
   localparam int SET_W   = $clog2(SETS);
   localparam int SET_IW  = (SET_W > 0) ? SET_W : 1;
   localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WC_W    = $clog2(WAYS + 1);
   localparam int LINES   = SETS * WAYS;
   localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int DA_W    = LINE_W + OFF_W;
   localparam int BC_W    = OFF_W + 1;
   localparam int MEM_SZ  = 2 ** ADDR_BITS;
   localparam int BW      = sawbc_pkg::BYTE_W;
   localparam int CW      = sawbc_pkg::TOTAL_W;
   // line state word: age, dirty, valid, tag from the top bit down
   localparam int LS_W    = WAY_W + 2 + TAG_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LK_RD, ST_LK_CMP, ST_VTAG_RD, ST_VTAG_WAIT,
      ST_WB_RD, ST_WB_WR, ST_FL_RD, ST_FL_WR, ST_ACC_RD, ST_ACC_WAIT,
      ST_AG_RD, ST_AG_WR, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic             act_ff, act_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [BW-1:0]    wdata_ff, wdata_in;
   logic [WC_W-1:0]  way_cnt_ff, way_cnt_in;
   logic             hit_ff, hit_in;
   logic [WAY_W-1:0] sel_ff, sel_in;
   logic [WAY_W-1:0] sel_age_ff, sel_age_in;
   logic             inv_found_ff, inv_found_in;
   logic [WAY_W-1:0] inv_way_ff, inv_way_in;
   logic [WAY_W-1:0] inv_age_ff, inv_age_in;
   logic [WAY_W-1:0] old_way_ff, old_way_in;
   logic [WAY_W-1:0] old_age_ff, old_age_in;
   logic             old_dirty_ff, old_dirty_in;
   logic             wb_ff, wb_in;
   logic [BC_W-1:0]  byte_ff, byte_in;
   logic [TAG_W-1:0] vtag_ff, vtag_in;
   logic [BW-1:0]    res_ff, res_in;
   logic [CW-1:0]    hits_ff, hits_in;
   logic [CW-1:0]    misses_ff, misses_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [sawbc_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // storage
   logic [LS_W-1:0]  line_mem [LINES];
   logic [BW-1:0]    data_mem [LINES * BLOCK_BYTES];
   logic [BW-1:0]    main_mem [MEM_SZ];
   logic [LS_W-1:0]  line_q_ff;
   logic [BW-1:0]    dm_q_ff;
   logic [BW-1:0]    mm_q_ff;

   logic [LINE_W-1:0]    ls_addr;
   logic                 ls_we;
   logic [LS_W-1:0]      ls_wdata;
   logic [DA_W-1:0]      dm_addr;
   logic                 dm_we;
   logic [BW-1:0]        dm_wdata;
   logic [ADDR_BITS-1:0] mm_addr;
   logic                 mm_we;
   logic [BW-1:0]        mm_wdata;

   // fields of the line state just read
   logic [TAG_W-1:0] q_tag;
   logic             q_valid;
   logic             q_dirty;
   logic [WAY_W-1:0] q_age;

   // address split of the transaction in flight
   logic [OFF_W-1:0]  cur_off;
   logic [SET_IW-1:0] cur_set;
   logic [TAG_W-1:0]  cur_tag;
   logic [LINE_W-1:0] set_base;
   logic [WAY_W-1:0]  cur_way;
   logic [LINE_W-1:0] cur_line;
   logic [LINE_W-1:0] sel_line;
   logic [WAY_W-1:0]  vic_way;
   logic [WAY_W-1:0]  vic_age;
   logic              vic_dirty;
   logic              last_byte;
   logic [ADDR_BITS-1:0] own_block;
   logic [ADDR_BITS-1:0] vic_block;

   assign q_tag   = line_q_ff[TAG_W-1:0];
   assign q_valid = line_q_ff[TAG_W];
   assign q_dirty = line_q_ff[TAG_W+1];
   assign q_age   = line_q_ff[LS_W-1 -: WAY_W];

   assign cur_off  = addr_ff[OFF_W-1:0];
   assign cur_set  = (SETS > 1) ? addr_ff[OFF_W +: SET_IW] : '0;
   assign cur_tag  = addr_ff[ADDR_BITS-1 -: TAG_W];
   assign set_base = LINE_W'(cur_set) * LINE_W'(WAYS);
   assign cur_way  = way_cnt_ff[WAY_W-1:0];
   assign cur_line = set_base + LINE_W'(cur_way);
   assign sel_line = set_base + LINE_W'(sel_ff);
   assign last_byte = (byte_ff == BC_W'(BLOCK_BYTES - 1));

   // block base addresses in main memory, wrapping at the memory size
   assign own_block = (ADDR_BITS'(cur_tag) << (OFF_W + SET_W))
                    | (ADDR_BITS'(cur_set) << OFF_W);
   assign vic_block = (ADDR_BITS'(vtag_ff) << (OFF_W + SET_W))
                    | (ADDR_BITS'(cur_set) << OFF_W);

   // victim: lowest invalid way, else the oldest, with the way now compared
   // an invalid line is never dirty
   always_comb begin
      if (inv_found_ff) begin
         vic_way   = inv_way_ff;
         vic_age   = inv_age_ff;
         vic_dirty = 1'b0;
      end else if (!q_valid) begin
         vic_way   = cur_way;
         vic_age   = q_age;
         vic_dirty = 1'b0;
      end else if (cur_way == '0 || q_age > old_age_ff) begin
         vic_way   = cur_way;
         vic_age   = q_age;
         vic_dirty = q_dirty;
      end else begin
         vic_way   = old_way_ff;
         vic_age   = old_age_ff;
         vic_dirty = old_dirty_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      addr_in      = addr_ff;
      wdata_in     = wdata_ff;
      way_cnt_in   = way_cnt_ff;
      hit_in       = hit_ff;
      sel_in       = sel_ff;
      sel_age_in   = sel_age_ff;
      inv_found_in = inv_found_ff;
      inv_way_in   = inv_way_ff;
      inv_age_in   = inv_age_ff;
      old_way_in   = old_way_ff;
      old_age_in   = old_age_ff;
      old_dirty_in = old_dirty_ff;
      wb_in        = wb_ff;
      byte_in      = byte_ff;
      vtag_in      = vtag_ff;
      res_in       = res_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      ls_addr   = cur_line;
      ls_we     = 1'b0;
      ls_wdata  = '0;
      dm_addr   = {sel_line, cur_off};
      dm_we     = 1'b0;
      dm_wdata  = wdata_ff;
      mm_addr   = clr_ff;
      mm_we     = 1'b0;
      mm_wdata  = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mm_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            // line state: invalid, clean, age equal to the way index
            if (clr_ff < ADDR_BITS'(LINES)) begin
               ls_we    = 1'b1;
               ls_addr  = clr_ff[LINE_W-1:0];
               ls_wdata = {cur_way, 2'b00, {TAG_W{1'b0}}};
               if (way_cnt_ff == WC_W'(WAYS - 1)) begin
                  way_cnt_in = '0;
               end else begin
                  way_cnt_in = way_cnt_ff + 1'b1;
               end
            end
            if (clr_ff == ADDR_BITS'(MEM_SZ - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in       = req_tuser[0];
               addr_in      = req_tdata[ADDR_BITS-1:0];
               wdata_in     = req_tdata[ADDR_BITS +: BW];
               way_cnt_in   = '0;
               hit_in       = 1'b0;
               inv_found_in = 1'b0;
               wb_in        = 1'b0;
               state_in     = ST_LK_RD;
            end
         end
         ST_LK_RD: begin
            ls_addr  = cur_line;
            state_in = ST_LK_CMP;
         end
         ST_LK_CMP: begin
            if (q_valid && q_tag == cur_tag) begin
               hit_in     = 1'b1;
               sel_in     = cur_way;
               sel_age_in = q_age;
               state_in   = ST_ACC_RD;
            end else if (way_cnt_ff == WC_W'(WAYS - 1)) begin
               sel_in     = vic_way;
               sel_age_in = vic_age;
               byte_in    = '0;
               if (vic_dirty) begin
                  state_in = ST_VTAG_RD;
               end else begin
                  state_in = ST_FL_RD;
               end
            end else begin
               if (!q_valid && !inv_found_ff) begin
                  inv_found_in = 1'b1;
                  inv_way_in   = cur_way;
                  inv_age_in   = q_age;
               end
               if (cur_way == '0 || q_age > old_age_ff) begin
                  old_way_in   = cur_way;
                  old_age_in   = q_age;
                  old_dirty_in = q_dirty;
               end
               way_cnt_in = way_cnt_ff + 1'b1;
               state_in   = ST_LK_RD;
            end
         end
         ST_VTAG_RD: begin
            ls_addr  = sel_line;
            state_in = ST_VTAG_WAIT;
         end
         ST_VTAG_WAIT: begin
            vtag_in  = q_tag;
            state_in = ST_WB_RD;
         end
         ST_WB_RD: begin
            dm_addr  = {sel_line, byte_ff[OFF_W-1:0]};
            state_in = ST_WB_WR;
         end
         ST_WB_WR: begin
            mm_we    = 1'b1;
            mm_addr  = vic_block | ADDR_BITS'(byte_ff[OFF_W-1:0]);
            mm_wdata = dm_q_ff;
            if (last_byte) begin
               wb_in    = 1'b1;
               byte_in  = '0;
               state_in = ST_FL_RD;
            end else begin
               byte_in  = byte_ff + 1'b1;
               state_in = ST_WB_RD;
            end
         end
         ST_FL_RD: begin
            mm_addr  = own_block | ADDR_BITS'(byte_ff[OFF_W-1:0]);
            state_in = ST_FL_WR;
         end
         ST_FL_WR: begin
            dm_we    = 1'b1;
            dm_addr  = {sel_line, byte_ff[OFF_W-1:0]};
            dm_wdata = mm_q_ff;
            if (last_byte) begin
               state_in = ST_ACC_RD;
            end else begin
               byte_in  = byte_ff + 1'b1;
               state_in = ST_FL_RD;
            end
         end
         ST_ACC_RD: begin
            dm_addr = {sel_line, cur_off};
            if (act_ff == sawbc_pkg::ACTION_WRITE) begin
               dm_we = 1'b1;
            end
            state_in = ST_ACC_WAIT;
         end
         ST_ACC_WAIT: begin
            res_in = (act_ff == sawbc_pkg::ACTION_WRITE) ? wdata_ff : dm_q_ff;
            if (hit_ff) begin
               hits_in = hits_ff + 1'b1;
            end else begin
               misses_in = misses_ff + 1'b1;
            end
            way_cnt_in = '0;
            state_in   = ST_AG_RD;
         end
         ST_AG_RD: begin
            ls_addr  = cur_line;
            state_in = ST_AG_WR;
         end
         ST_AG_WR: begin
            // lru update: younger ways age by one, the used way becomes newest
            // and takes the new tag, valid and dirty state
            ls_we   = 1'b1;
            ls_addr = cur_line;
            if (cur_way == sel_ff) begin
               ls_wdata = {{WAY_W{1'b0}},
                           (act_ff == sawbc_pkg::ACTION_WRITE) || (hit_ff && q_dirty),
                           1'b1, cur_tag};
            end else if (q_age < sel_age_ff) begin
               ls_wdata = {q_age + 1'b1, q_dirty, q_valid, q_tag};
            end else begin
               ls_wdata = line_q_ff;
            end
            if (way_cnt_ff == WC_W'(WAYS - 1)) begin
               state_in = ST_DONE;
            end else begin
               way_cnt_in = way_cnt_ff + 1'b1;
               state_in   = ST_AG_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sawbc_pkg::RSP_W'({misses_ff, hits_ff, wb_ff, hit_ff, res_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         way_cnt_ff   <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         way_cnt_ff   <= way_cnt_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      hit_ff       <= hit_in;
      sel_ff       <= sel_in;
      sel_age_ff   <= sel_age_in;
      inv_found_ff <= inv_found_in;
      inv_way_ff   <= inv_way_in;
      inv_age_ff   <= inv_age_in;
      old_way_ff   <= old_way_in;
      old_age_ff   <= old_age_in;
      old_dirty_ff <= old_dirty_in;
      wb_ff        <= wb_in;
      byte_ff      <= byte_in;
      vtag_ff      <= vtag_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // line state store: tag, valid, dirty and age per line
   always_ff @(posedge clock) begin
      if (ls_we) begin
         line_mem[ls_addr] <= ls_wdata;
      end
      line_q_ff <= line_mem[ls_addr];
   end

   // line data store
   always_ff @(posedge clock) begin
      if (dm_we) begin
         data_mem[dm_addr] <= dm_wdata;
      end
      dm_q_ff <= data_mem[dm_addr];
   end

   // main memory
   always_ff @(posedge clock) begin
      if (mm_we) begin
         main_mem[mm_addr] <= mm_wdata;
      end
      mm_q_ff <= main_mem[mm_addr];
   end

endmodule
